### sv/dce_pkg.sv
// ----------------------------------------------------------------------------
// Direct convolution engine package
// Sizes, field widths, opcodes, register indexes and shared types of the
// direct 2D convolution engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dce_pkg;

	localparam int IN_CHANNELS   = 3;
	localparam int OUT_CHANNELS  = 4;
	localparam int KERNEL_ROWS   = 2;
	localparam int KERNEL_COLS   = 2;
	localparam int MAX_DIM       = 8;
	localparam int WEIGHT_COUNT  = 48;
	localparam int SAMPLE_COUNT  = IN_CHANNELS * MAX_DIM * MAX_DIM;
	localparam int OUT_DIM_LIMIT = 4;
	localparam int OUT_CH_RUN    = (OUT_CHANNELS < OUT_DIM_LIMIT) ? OUT_CHANNELS : OUT_DIM_LIMIT;

	// Reset weights step up by one every RESET_GROUP entries.
	localparam int RESET_GROUP = 12;
	localparam int Q_ONE       = 256;

	localparam int OPCODE_W   = 2;
	localparam int SLOT_W     = 8;
	localparam int SAMPLE_W   = 16;
	localparam int PROD_W     = 2 * SAMPLE_W;
	localparam int SUM_W      = 35;
	localparam int COORD_W    = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;
	localparam int STEP_W     = 3;
	localparam int IN_DIM_W   = 4;
	localparam int OUT_DIM_W  = 3;

	localparam int WADDR_W = $clog2(WEIGHT_COUNT);
	localparam int SADDR_W = $clog2(SAMPLE_COUNT);
	localparam int DIM_IDX_W = $clog2(MAX_DIM);
	localparam int POS_W   = 6;
	localparam int WI_W    = 7;
	localparam int IC_W    = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
	localparam int KR_W    = (KERNEL_ROWS > 1) ? $clog2(KERNEL_ROWS) : 1;
	localparam int KC_W    = (KERNEL_COLS > 1) ? $clog2(KERNEL_COLS) : 1;
	localparam int OC_W    = (OUT_CH_RUN > 1) ? $clog2(OUT_CH_RUN) : 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [OPCODE_W-1:0] OP_WEIGHT = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_RUN    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd5;

	typedef enum logic [1:0] {
		K_WEIGHT,
		K_SAMPLE,
		K_RUN
	} kind_t;

	typedef struct packed {
		kind_t                      kind;
		logic [SLOT_W-1:0]          addr;
		logic signed [SAMPLE_W-1:0] data;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} q_head_t;

	// Q8.8 reset value of a weight entry: one more unit for every group
	// boundary that the index has passed.
	function automatic logic signed [SAMPLE_W-1:0] weight_reset(input logic [WADDR_W-1:0] idx);
		logic [SAMPLE_W-1:0] value;
		value = SAMPLE_W'(Q_ONE);
		for (int g = 1; g * RESET_GROUP < WEIGHT_COUNT; g++) begin
			if (int'(idx) >= g * RESET_GROUP) begin
				value = value + SAMPLE_W'(Q_ONE);
			end
		end
		return value;
	endfunction

endpackage

### sv/dce_in_if.sv
// ----------------------------------------------------------------------------
// Input request channel
// Carries one opcode, slot and sample per request with valid and ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dce_in_if;
	logic                                valid;
	logic                                ready;
	logic [dce_pkg::OPCODE_W-1:0]        opcode;
	logic [dce_pkg::SLOT_W-1:0]          slot;
	logic signed [dce_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output opcode, output slot, output sample, input ready);
	modport sink (input valid, input opcode, input slot, input sample, output ready);
endinterface

### sv/dce_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Carries one convolution output with its coordinates and the last mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dce_out_if;
	logic                             valid;
	logic                             ready;
	logic [dce_pkg::COORD_W-1:0]      out_channel;
	logic [dce_pkg::COORD_W-1:0]      out_row;
	logic [dce_pkg::COORD_W-1:0]      out_col;
	logic signed [dce_pkg::SUM_W-1:0] sum_value;
	logic                             last;

	modport source (output valid, output out_channel, output out_row, output out_col,
		output sum_value, output last, input ready);
	modport sink (input valid, input out_channel, input out_row, input out_col,
		input sum_value, input last, output ready);
endinterface

### sv/dce_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and write data with valid and ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dce_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [dce_pkg::CFG_IDX_W-1:0]  index;
	logic [dce_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### sv/dce_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/dce_front.sv
// ----------------------------------------------------------------------------
// Convolution engine front end
// Accepts requests, drops the ones that do nothing and queues the rest
// for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dce_front (
	input  logic             clk,
	input  logic             arst_n,
	dce_in_if.sink           in_ch,
	input  logic             pop,
	output dce_pkg::q_head_t head
);

	dce_pkg::entry_t      mem_q [dce_pkg::QUEUE_DEPTH];
	logic [dce_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [dce_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [dce_pkg::QPTR_W:0]   count_q;
	logic                       keep;
	logic                       push;
	dce_pkg::kind_t             kind;

	// Out-of-range writes and the unused opcode are taken and dropped here.
	always_comb begin
		keep = 1'b0;
		kind = dce_pkg::K_RUN;
		case (in_ch.opcode)
			dce_pkg::OP_WEIGHT: begin
				keep = in_ch.slot < dce_pkg::SLOT_W'(dce_pkg::WEIGHT_COUNT);
				kind = dce_pkg::K_WEIGHT;
			end
			dce_pkg::OP_SAMPLE: begin
				keep = in_ch.slot < dce_pkg::SLOT_W'(dce_pkg::SAMPLE_COUNT);
				kind = dce_pkg::K_SAMPLE;
			end
			dce_pkg::OP_RUN: begin
				keep = 1'b1;
				kind = dce_pkg::K_RUN;
			end
			default: begin
				keep = 1'b0;
				kind = dce_pkg::K_RUN;
			end
		endcase
	end

	assign in_ch.ready = count_q != (dce_pkg::QPTR_W + 1)'(dce_pkg::QUEUE_DEPTH);
	assign push        = in_ch.valid && in_ch.ready && keep;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{kind: kind, addr: in_ch.slot, data: in_ch.sample};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head.valid = count_q != '0;
	assign head.entry = mem_q[rd_ptr_q];

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("back end popped an empty queue");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue fill count missed a push");

endmodule

### sv/dce_back.sv
// ----------------------------------------------------------------------------
// Convolution engine back end
// Holds the configuration registers and both stores, performs queued
// writes and walks every output window tap by tap through a
// read, multiply and accumulate pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dce_back (
	input  logic             clk,
	input  logic             arst_n,
	input  dce_pkg::q_head_t head,
	output logic             pop,
	dce_cfg_if.sink          cfg,
	dce_out_if.source        out_ch
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_ISSUE,
		B_WAIT,
		B_EMIT
	} state_t;

	state_t st_q;

	logic [dce_pkg::STEP_W-1:0]    step_x_q;
	logic [dce_pkg::STEP_W-1:0]    step_y_q;
	logic [dce_pkg::IN_DIM_W-1:0]  in_height_q;
	logic [dce_pkg::IN_DIM_W-1:0]  in_width_q;
	logic [dce_pkg::OUT_DIM_W-1:0] out_height_q;
	logic [dce_pkg::OUT_DIM_W-1:0] out_width_q;

	logic [dce_pkg::OC_W-1:0]      oc_q;
	logic [dce_pkg::COORD_W-1:0]   oy_q;
	logic [dce_pkg::COORD_W-1:0]   ox_q;
	logic [dce_pkg::OUT_DIM_W-1:0] oh_q;
	logic [dce_pkg::OUT_DIM_W-1:0] ow_q;
	logic [dce_pkg::IC_W-1:0]      ic_q;
	logic [dce_pkg::KR_W-1:0]      kr_q;
	logic [dce_pkg::KC_W-1:0]      kc_q;

	logic [dce_pkg::OUT_DIM_W-1:0] oh_sat;
	logic [dce_pkg::OUT_DIM_W-1:0] ow_sat;
	logic [dce_pkg::IN_DIM_W-1:0]  rows;
	logic [dce_pkg::IN_DIM_W-1:0]  cols;
	logic [dce_pkg::POS_W-1:0]     row_pos;
	logic [dce_pkg::POS_W-1:0]     col_pos;
	logic [dce_pkg::WI_W-1:0]      widx;
	logic [dce_pkg::SADDR_W-1:0]   saddr;
	logic                          tap_in;
	logic                          tap_first;
	logic                          tap_last;
	logic                          out_free;
	logic                          pos_last;
	logic                          issue;

	logic                          valid_s1;
	logic                          in_s1;
	logic                          first_s1;
	logic                          last_s1;
	logic [dce_pkg::WADDR_W-1:0]   waddr_s1;
	logic signed [dce_pkg::SAMPLE_W-1:0] sample_s1;
	logic signed [dce_pkg::SAMPLE_W-1:0] weight_s1;
	logic [dce_pkg::SAMPLE_W-1:0]  srdata;
	logic [dce_pkg::SAMPLE_W-1:0]  wrdata;
	logic signed [dce_pkg::PROD_W-1:0] prod_s1;

	logic                          valid_s2;
	logic                          first_s2;
	logic                          last_s2;
	logic signed [dce_pkg::PROD_W-1:0] prod_s2;

	logic signed [dce_pkg::SUM_W-1:0] acc_q;
	logic [dce_pkg::WEIGHT_COUNT-1:0] wvalid_q;

	logic we_weight;
	logic we_sample;

	// Configuration registers; writes to unknown indexes are taken and ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q     <= 3'd2;
			step_y_q     <= 3'd2;
			in_height_q  <= 4'd4;
			in_width_q   <= 4'd4;
			out_height_q <= 3'd2;
			out_width_q  <= 3'd2;
		end else if (cfg.valid) begin
			case (cfg.index)
				dce_pkg::REG_STEP_X:     step_x_q     <= cfg.data[dce_pkg::STEP_W-1:0];
				dce_pkg::REG_STEP_Y:     step_y_q     <= cfg.data[dce_pkg::STEP_W-1:0];
				dce_pkg::REG_IN_HEIGHT:  in_height_q  <= cfg.data[dce_pkg::IN_DIM_W-1:0];
				dce_pkg::REG_IN_WIDTH:   in_width_q   <= cfg.data[dce_pkg::IN_DIM_W-1:0];
				dce_pkg::REG_OUT_HEIGHT: out_height_q <= cfg.data[dce_pkg::OUT_DIM_W-1:0];
				dce_pkg::REG_OUT_WIDTH:  out_width_q  <= cfg.data[dce_pkg::OUT_DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign oh_sat = (out_height_q > dce_pkg::OUT_DIM_W'(dce_pkg::OUT_DIM_LIMIT)) ?
		dce_pkg::OUT_DIM_W'(dce_pkg::OUT_DIM_LIMIT) : out_height_q;
	assign ow_sat = (out_width_q > dce_pkg::OUT_DIM_W'(dce_pkg::OUT_DIM_LIMIT)) ?
		dce_pkg::OUT_DIM_W'(dce_pkg::OUT_DIM_LIMIT) : out_width_q;
	assign rows = (in_height_q > dce_pkg::IN_DIM_W'(dce_pkg::MAX_DIM)) ?
		dce_pkg::IN_DIM_W'(dce_pkg::MAX_DIM) : in_height_q;
	assign cols = (in_width_q > dce_pkg::IN_DIM_W'(dce_pkg::MAX_DIM)) ?
		dce_pkg::IN_DIM_W'(dce_pkg::MAX_DIM) : in_width_q;

	// Window tap addressing for the current output and kernel position.
	assign row_pos = dce_pkg::POS_W'(oy_q) * dce_pkg::POS_W'(step_y_q) + dce_pkg::POS_W'(kr_q);
	assign col_pos = dce_pkg::POS_W'(ox_q) * dce_pkg::POS_W'(step_x_q) + dce_pkg::POS_W'(kc_q);
	assign widx = dce_pkg::WI_W'(((int'(oc_q) * dce_pkg::IN_CHANNELS + int'(ic_q))
		* dce_pkg::KERNEL_ROWS + int'(kr_q)) * dce_pkg::KERNEL_COLS + int'(kc_q));
	assign saddr = dce_pkg::SADDR_W'(int'(ic_q) * dce_pkg::MAX_DIM * dce_pkg::MAX_DIM
		+ int'(row_pos[dce_pkg::DIM_IDX_W-1:0]) * dce_pkg::MAX_DIM
		+ int'(col_pos[dce_pkg::DIM_IDX_W-1:0]));
	assign tap_in = (row_pos < dce_pkg::POS_W'(rows)) && (col_pos < dce_pkg::POS_W'(cols))
		&& (widx < dce_pkg::WI_W'(dce_pkg::WEIGHT_COUNT));
	assign tap_first = (ic_q == '0) && (kr_q == '0) && (kc_q == '0);
	assign tap_last = (ic_q == dce_pkg::IC_W'(dce_pkg::IN_CHANNELS - 1))
		&& (kr_q == dce_pkg::KR_W'(dce_pkg::KERNEL_ROWS - 1))
		&& (kc_q == dce_pkg::KC_W'(dce_pkg::KERNEL_COLS - 1));
	assign issue = st_q == B_ISSUE;

	assign pop       = (st_q == B_IDLE) && head.valid;
	assign we_weight = pop && (head.entry.kind == dce_pkg::K_WEIGHT);
	assign we_sample = pop && (head.entry.kind == dce_pkg::K_SAMPLE);

	dce_ram #(
		.WIDTH (dce_pkg::SAMPLE_W),
		.DEPTH (dce_pkg::WEIGHT_COUNT)
	) u_weight_ram (
		.clk   (clk),
		.we    (we_weight),
		.waddr (head.entry.addr[dce_pkg::WADDR_W-1:0]),
		.wdata (head.entry.data),
		.raddr (widx[dce_pkg::WADDR_W-1:0]),
		.rdata (wrdata)
	);

	dce_ram #(
		.WIDTH (dce_pkg::SAMPLE_W),
		.DEPTH (dce_pkg::SAMPLE_COUNT)
	) u_sample_ram (
		.clk   (clk),
		.we    (we_sample),
		.waddr (head.entry.addr[dce_pkg::SADDR_W-1:0]),
		.wdata (head.entry.data),
		.raddr (saddr),
		.rdata (srdata)
	);

	// A weight entry that was never written reads as its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
		end else if (we_weight) begin
			wvalid_q[head.entry.addr[dce_pkg::WADDR_W-1:0]] <= 1'b1;
		end
	end

	assign sample_s1 = srdata;
	assign weight_s1 = wvalid_q[waddr_s1] ? wrdata : dce_pkg::weight_reset(waddr_s1);
	assign prod_s1   = sample_s1 * weight_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		in_s1    <= tap_in;
		first_s1 <= tap_first;
		last_s1  <= tap_last;
		waddr_s1 <= widx[dce_pkg::WADDR_W-1:0];
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		prod_s2  <= in_s1 ? prod_s1 : '0;
		if (valid_s2) begin
			acc_q <= first_s2 ? dce_pkg::SUM_W'(prod_s2) : acc_q + dce_pkg::SUM_W'(prod_s2);
		end
	end

	assign out_free = !out_ch.valid || out_ch.ready;
	assign pos_last = (oc_q == dce_pkg::OC_W'(dce_pkg::OUT_CH_RUN - 1))
		&& ({1'b0, oy_q} == oh_q - 3'd1) && ({1'b0, ox_q} == ow_q - 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q               <= B_IDLE;
			oc_q               <= '0;
			oy_q               <= '0;
			ox_q               <= '0;
			oh_q               <= '0;
			ow_q               <= '0;
			ic_q               <= '0;
			kr_q               <= '0;
			kc_q               <= '0;
			out_ch.valid       <= 1'b0;
			out_ch.out_channel <= '0;
			out_ch.out_row     <= '0;
			out_ch.out_col     <= '0;
			out_ch.sum_value   <= '0;
			out_ch.last        <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready && (st_q != B_EMIT)) begin
				out_ch.valid <= 1'b0;
			end
			case (st_q)
				B_IDLE: begin
					if (pop && (head.entry.kind == dce_pkg::K_RUN)
						&& (oh_sat != '0) && (ow_sat != '0)) begin
						oh_q <= oh_sat;
						ow_q <= ow_sat;
						oc_q <= '0;
						oy_q <= '0;
						ox_q <= '0;
						ic_q <= '0;
						kr_q <= '0;
						kc_q <= '0;
						st_q <= B_ISSUE;
					end
				end
				B_ISSUE: begin
					if (kc_q == dce_pkg::KC_W'(dce_pkg::KERNEL_COLS - 1)) begin
						kc_q <= '0;
						if (kr_q == dce_pkg::KR_W'(dce_pkg::KERNEL_ROWS - 1)) begin
							kr_q <= '0;
							if (ic_q == dce_pkg::IC_W'(dce_pkg::IN_CHANNELS - 1)) begin
								ic_q <= '0;
								st_q <= B_WAIT;
							end else begin
								ic_q <= ic_q + 1'b1;
							end
						end else begin
							kr_q <= kr_q + 1'b1;
						end
					end else begin
						kc_q <= kc_q + 1'b1;
					end
				end
				B_WAIT: begin
					if (valid_s2 && last_s2) begin
						st_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (out_free) begin
						out_ch.valid       <= 1'b1;
						out_ch.out_channel <= dce_pkg::COORD_W'(oc_q);
						out_ch.out_row     <= oy_q;
						out_ch.out_col     <= ox_q;
						out_ch.sum_value   <= acc_q;
						out_ch.last        <= pos_last;
						st_q               <= B_ISSUE;
						if ({1'b0, ox_q} == ow_q - 3'd1) begin
							ox_q <= '0;
							if ({1'b0, oy_q} == oh_q - 3'd1) begin
								oy_q <= '0;
								if (oc_q == dce_pkg::OC_W'(dce_pkg::OUT_CH_RUN - 1)) begin
									oc_q <= '0;
									st_q <= B_IDLE;
								end else begin
									oc_q <= oc_q + 1'b1;
								end
							end else begin
								oy_q <= oy_q + 1'b1;
							end
						end else begin
							ox_q <= ox_q + 1'b1;
						end
					end
				end
				default: begin
					st_q <= B_IDLE;
				end
			endcase
		end
	end

	a_no_write_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !valid_s1 && !valid_s2)
		else $error("store write while window reads are in flight");

	a_last_tap_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && last_s2) |=> st_q == B_EMIT)
		else $error("finished window sum not handed to the output stage");

	a_run_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_EMIT && out_free && pos_last) |=> st_q == B_IDLE && out_ch.last)
		else $error("run did not end on its last output");

endmodule

### sv/direct_conv2d_engine.sv
// ----------------------------------------------------------------------------
// Direct 2D convolution engine
// Weight and sample writes are performed by the back end while it is idle;
// a run walks the 12 taps of each output window through the shared
// multiplier, waits on the read and multiply pipeline, then loads the output
// register once the output is free; no queued request is taken until the
// run ends. A two-entry queue decouples intake.
// Reset restores the registers and the weight reset values at once through
// per-entry valid bits; the sample store has no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module direct_conv2d_engine (
	input  logic      clk,
	input  logic      arst_n,
	dce_in_if.sink    in_ch,
	dce_cfg_if.sink   cfg,
	dce_out_if.source out_ch
);

	dce_pkg::q_head_t head;
	logic             pop;

	dce_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.pop    (pop),
		.head   (head)
	);

	dce_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.cfg    (cfg),
		.out_ch (out_ch)
	);

endmodule

### tb/direct_conv2d_engine_tb.sv
// ----------------------------------------------------------------------------
// Direct convolution engine testbench
// Drives weight, sample and run requests and register writes into the
// engine. Each accepted request updates a local copy of the weight store,
// the sample store and the registers, and each run queues the sums it must
// produce. Outputs are compared in order, field by field. A short directed
// part covers reset weights, extreme values, ignored slots and opcodes and
// the odd register settings and one long output hold-off. Random
// load-and-run sequences follow, with random idle cycles on every channel but in one steady pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module direct_conv2d_engine_tb;
	import dce_pkg::*;

	localparam logic [OPCODE_W-1:0]  OP_UNUSED    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int SLOT_TOP      = (1 << SLOT_W) - 1;
	localparam int ITEM_TARGET   = 430;
	localparam int SETTLE_CYCLES = 40;
	localparam int SINK_HOLD     = 300;
	localparam int STALL_LIMIT   = 3000;
	localparam longint SUM_MAX   = (64'sd1 <<< (SUM_W - 1)) - 1;
	localparam longint SUM_MIN   = -(64'sd1 <<< (SUM_W - 1));

	typedef struct packed {
		logic [COORD_W-1:0]      channel;
		logic [COORD_W-1:0]      row;
		logic [COORD_W-1:0]      col;
		logic signed [SUM_W-1:0] total;
		logic                    last;
	} conv_result_t;

	class conv_scoreboard;
		logic signed [SAMPLE_W-1:0] weights [WEIGHT_COUNT];
		logic signed [SAMPLE_W-1:0] samples [SAMPLE_COUNT];
		logic [STEP_W-1:0]          step_x, step_y;
		logic [IN_DIM_W-1:0]        in_h, in_w;
		logic [OUT_DIM_W-1:0]       out_h, out_w;
		conv_result_t               pending_outputs [$];
		int                         errors;

		function new();
			step_x = 3'd2;
			step_y = 3'd2;
			in_h   = 4'd4;
			in_w   = 4'd4;
			out_h  = 3'd2;
			out_w  = 3'd2;
			for (int i = 0; i < WEIGHT_COUNT; i++)
				weights[i] = SAMPLE_W'(Q_ONE * (1 + i / RESET_GROUP));
			for (int i = 0; i < SAMPLE_COUNT; i++)
				samples[i] = '0;
			errors = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_STEP_X:     step_x = value[STEP_W-1:0];
				REG_STEP_Y:     step_y = value[STEP_W-1:0];
				REG_IN_HEIGHT:  in_h   = value[IN_DIM_W-1:0];
				REG_IN_WIDTH:   in_w   = value[IN_DIM_W-1:0];
				REG_OUT_HEIGHT: out_h  = value[OUT_DIM_W-1:0];
				REG_OUT_WIDTH:  out_w  = value[OUT_DIM_W-1:0];
				default: ;
			endcase
		endfunction

		// Taps that fall outside the rows and columns in use contribute nothing.
		function logic signed [SUM_W-1:0] window_sum(int oc, int oy, int ox);
			int rows, cols, r, c, wi, prod;
			longint acc;
			rows = (in_h < MAX_DIM) ? in_h : MAX_DIM;
			cols = (in_w < MAX_DIM) ? in_w : MAX_DIM;
			acc = 0;
			for (int ic = 0; ic < IN_CHANNELS; ic++)
				for (int kr = 0; kr < KERNEL_ROWS; kr++)
					for (int kc = 0; kc < KERNEL_COLS; kc++) begin
						r = oy * step_y + kr;
						c = ox * step_x + kc;
						wi = ((oc * IN_CHANNELS + ic) * KERNEL_ROWS + kr) * KERNEL_COLS + kc;
						if (r < rows && c < cols && wi < WEIGHT_COUNT) begin
							prod = samples[ic * MAX_DIM * MAX_DIM + r * MAX_DIM + c] * weights[wi];
							acc += prod;
						end
					end
			if (acc > SUM_MAX)
				acc = SUM_MAX;
			if (acc < SUM_MIN)
				acc = SUM_MIN;
			return acc[SUM_W-1:0];
		endfunction

		function void queue_run_outputs();
			int oh, ow, count, n;
			conv_result_t want;
			oh = (out_h < OUT_DIM_LIMIT) ? out_h : OUT_DIM_LIMIT;
			ow = (out_w < OUT_DIM_LIMIT) ? out_w : OUT_DIM_LIMIT;
			count = OUT_CH_RUN * oh * ow;
			n = 0;
			for (int oc = 0; oc < OUT_CH_RUN; oc++)
				for (int oy = 0; oy < oh; oy++)
					for (int ox = 0; ox < ow; ox++) begin
						n++;
						want.channel = oc;
						want.row     = oy;
						want.col     = ox;
						want.total   = window_sum(oc, oy, ox);
						want.last    = (n == count);
						pending_outputs.push_back(want);
					end
		endfunction

		function void note_request(logic [OPCODE_W-1:0] op, logic [SLOT_W-1:0] slot,
			logic signed [SAMPLE_W-1:0] value);
			case (op)
				OP_WEIGHT: if (slot < WEIGHT_COUNT) weights[slot] = value;
				OP_SAMPLE: if (slot < SAMPLE_COUNT) samples[slot] = value;
				OP_RUN:    queue_run_outputs();
				default: ;
			endcase
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_result(conv_result_t got);
			conv_result_t want;
			if (pending_outputs.size() == 0) begin
				report_mismatch($sformatf("output with nothing pending: ch %0d row %0d col %0d",
					got.channel, got.row, got.col));
				return;
			end
			want = pending_outputs.pop_front();
			if (got.channel !== want.channel)
				report_mismatch($sformatf("channel %0d, want %0d", got.channel, want.channel));
			if (got.row !== want.row)
				report_mismatch($sformatf("row %0d, want %0d (ch %0d)", got.row, want.row,
					want.channel));
			if (got.col !== want.col)
				report_mismatch($sformatf("col %0d, want %0d (ch %0d row %0d)", got.col, want.col,
					want.channel, want.row));
			if (got.total !== want.total)
				report_mismatch($sformatf("sum %0d, want %0d (ch %0d row %0d col %0d)", got.total,
					want.total, want.channel, want.row, want.col));
			if (got.last !== want.last)
				report_mismatch($sformatf("last %0b, want %0b (ch %0d row %0d col %0d)", got.last,
					want.last, want.channel, want.row, want.col));
		endtask
	endclass

	logic           clk = 1'b0;
	logic           arst_n;
	bit             steady;
	bit             hold_pending;
	int             work_items;
	bit             sample_loaded [SAMPLE_COUNT];
	conv_scoreboard sb;

	dce_in_if  in_bus ();
	dce_cfg_if cfg_bus ();
	dce_out_if out_bus ();

	direct_conv2d_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_bus),
		.cfg    (cfg_bus),
		.out_ch (out_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	function automatic logic signed [SAMPLE_W-1:0] rand_q88();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			default: return $urandom;
		endcase
	endfunction

	// Valid stays high after a request is taken, so the caller either sends
	// the next request or lowers valid in the same time step.
	task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [SLOT_W-1:0] slot,
		input logic signed [SAMPLE_W-1:0] value);
		if (!steady)
			while ($urandom_range(0, 99) < 10) begin
				in_bus.valid <= 1'b0;
				@(posedge clk);
			end
		in_bus.valid  <= 1'b1;
		in_bus.opcode <= op;
		in_bus.slot   <= slot;
		in_bus.sample <= value;
		@(posedge clk);
		while (!in_bus.ready) @(posedge clk);
		sb.note_request(op, slot, value);
		if (op == OP_SAMPLE && slot < SAMPLE_COUNT)
			sample_loaded[slot] = 1'b1;
		if ((op == OP_WEIGHT && slot < WEIGHT_COUNT) || (op == OP_SAMPLE && slot < SAMPLE_COUNT)
			|| op == OP_RUN)
			work_items++;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		if (!steady)
			while ($urandom_range(0, 99) < 10) begin
				cfg_bus.valid <= 1'b0;
				@(posedge clk);
			end
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		sb.set_register(idx, value);
	endtask

	task automatic load_config(input logic [CFG_DATA_W-1:0] sx, input logic [CFG_DATA_W-1:0] sy,
		input logic [CFG_DATA_W-1:0] ih, input logic [CFG_DATA_W-1:0] iw,
		input logic [CFG_DATA_W-1:0] oh, input logic [CFG_DATA_W-1:0] ow);
		write_register(REG_STEP_X, sx);
		write_register(REG_STEP_Y, sy);
		write_register(REG_IN_HEIGHT, ih);
		write_register(REG_IN_WIDTH, iw);
		write_register(REG_OUT_HEIGHT, oh);
		write_register(REG_OUT_WIDTH, ow);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		in_bus.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_outputs.size() != 0) @(posedge clk);
	endtask

	// Writes can leave the engine busy after the last output has come out.
	task automatic settle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Every sample that the next run will read must have been written first.
	task automatic load_run_window();
		int rows, cols, oh, ow, r, c, addr;
		rows = (sb.in_h < MAX_DIM) ? sb.in_h : MAX_DIM;
		cols = (sb.in_w < MAX_DIM) ? sb.in_w : MAX_DIM;
		oh = (sb.out_h < OUT_DIM_LIMIT) ? sb.out_h : OUT_DIM_LIMIT;
		ow = (sb.out_w < OUT_DIM_LIMIT) ? sb.out_w : OUT_DIM_LIMIT;
		for (int ic = 0; ic < IN_CHANNELS; ic++)
			for (int oy = 0; oy < oh; oy++)
				for (int ox = 0; ox < ow; ox++)
					for (int kr = 0; kr < KERNEL_ROWS; kr++)
						for (int kc = 0; kc < KERNEL_COLS; kc++) begin
							r = oy * sb.step_y + kr;
							c = ox * sb.step_x + kc;
							addr = ic * MAX_DIM * MAX_DIM + r * MAX_DIM + c;
							if (r < rows && c < cols && !sample_loaded[addr])
								send_request(OP_SAMPLE, SLOT_W'(addr), rand_q88());
						end
	endtask

	initial begin : result_sink
		conv_result_t got;
		int hold_left;
		hold_left = 0;
		out_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_bus.valid && out_bus.ready) begin
				got = '{out_bus.out_channel, out_bus.out_row, out_bus.out_col, out_bus.sum_value,
					out_bus.last};
				sb.check_result(got);
			end
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = SINK_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_bus.ready <= 1'b0;
			end else begin
				out_bus.ready <= arst_n && (steady || $urandom_range(0, 99) >= 10);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		int phase;
		int sx, sy, ih, iw, oh, ow;
		sb = new();
		arst_n        <= 1'b0;
		in_bus.valid  <= 1'b0;
		in_bus.opcode <= OP_WEIGHT;
		in_bus.slot   <= '0;
		in_bus.sample <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= REG_STEP_X;
		cfg_bus.data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers and reset weights, extreme samples, ignored requests.
		send_request(OP_SAMPLE, 0, 16'sh7FFF);
		send_request(OP_SAMPLE, SAMPLE_COUNT - 1, 16'sh8000);
		send_request(OP_SAMPLE, SAMPLE_COUNT, 16'sh1234);
		send_request(OP_SAMPLE, SLOT_TOP, 16'sh7FFF);
		send_request(OP_UNUSED, SLOT_TOP, 16'shFFFF);
		load_run_window();
		send_request(OP_RUN, 0, 16'sh0000);
		send_request(OP_WEIGHT, 0, 16'sh8000);
		send_request(OP_WEIGHT, WEIGHT_COUNT - 1, 16'sh7FFF);
		send_request(OP_WEIGHT, WEIGHT_COUNT, 16'sh7FFF);
		send_request(OP_WEIGHT, SLOT_TOP, 16'sh8000);
		send_request(OP_RUN, SLOT_TOP, 16'shFFFF);

		// Largest run while the output side holds off: the engine must stall intake.
		settle();
		load_config(1, 1, 8, 8, 4, 4);
		load_run_window();
		hold_pending = 1'b1;
		send_request(OP_RUN, 0, 16'sh0000);
		repeat (6) send_request(OP_SAMPLE, $urandom_range(0, SAMPLE_COUNT - 1), rand_q88());
		wait_drained();
		send_request(OP_RUN, 0, 16'sh0000);

		// Wide strides push windows past a small input; sizes above four saturate.
		settle();
		load_config(4, 4, 2, 2, 7, 7);
		send_request(OP_RUN, 0, 16'sh0000);

		// Zero strides (bit 3 of the data is dropped), input sizes above the store.
		settle();
		write_register(REG_SPARE_LO, 15);
		write_register(REG_SPARE_HI, 15);
		load_config(8, 0, 15, 15, 1, 1);
		load_run_window();
		send_request(OP_RUN, 0, 16'sh0000);

		// A zero output size runs without any output.
		settle();
		load_config(2, 2, 4, 4, 0, 3);
		send_request(OP_RUN, 0, 16'sh0000);

		settle();
		load_config(3, 1, 0, 1, 2, 3);
		send_request(OP_RUN, 0, 16'sh0000);

		phase = 0;
		while (work_items < ITEM_TARGET) begin
			settle();
			steady = (phase == 1);
			sx = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 15);
			sy = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 15);
			ih = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 8) : $urandom_range(0, 15);
			iw = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 8) : $urandom_range(0, 15);
			oh = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 7);
			ow = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 7);
			if ($urandom_range(0, 4) == 0)
				write_register($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
			load_config(sx, sy, ih, iw, oh, ow);
			repeat ($urandom_range(3, 6)) begin
				repeat ($urandom_range(0, 4))
					send_request(OP_WEIGHT, $urandom_range(0, WEIGHT_COUNT - 1), rand_q88());
				repeat ($urandom_range(0, 6))
					send_request(OP_SAMPLE, $urandom_range(0, SAMPLE_COUNT - 1), rand_q88());
				case ($urandom_range(0, 19))
					0: send_request(OP_UNUSED, $urandom, $urandom);
					1: send_request(OP_WEIGHT, $urandom_range(WEIGHT_COUNT, SLOT_TOP), rand_q88());
					2: send_request(OP_SAMPLE, $urandom_range(SAMPLE_COUNT, SLOT_TOP), rand_q88());
					default: ;
				endcase
				load_run_window();
				send_request(OP_RUN, $urandom, $urandom);
				if ($urandom_range(0, 9) == 0)
					wait_drained();
			end
			phase++;
		end

		steady = 1'b0;
		settle();
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
